// ===== rtl/card_pair_outcome_accumulator_core_assert.svh =====
// Assertion macros shared by the card pair outcome accumulator RTL.
`ifndef CARD_PAIR_OUTCOME_ACCUMULATOR_CORE_ASSERT_SVH
`define CARD_PAIR_OUTCOME_ACCUMULATOR_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define CPOA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define CPOA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CPOA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CPOA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/cpoa_pkg.sv =====
// Package with widths, the entry record type and saturating helpers.
`default_nettype none
package cpoa_pkg;

    localparam int DECK_SIZE_DEF    = 52;
    localparam int PAIR_ENTRIES_DEF = 1326;

    localparam int CARD_W  = 6;
    localparam int DELTA_W = 16;
    localparam int INDEX_W = 11;
    localparam int CNT_W   = 31;
    localparam int SUM_W   = 32;
    // Width used while ranking a pair; holds every intermediate product.
    localparam int RANK_W  = 13;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef struct packed {
        logic [CNT_W-1:0] records;
        logic [SUM_W-1:0] delta_sum;
        logic [CNT_W-1:0] win_sum;
        logic [SUM_W-1:0] loss_sum;
        logic [CNT_W-1:0] wins;
        logic [CNT_W-1:0] losses;
        logic [CNT_W-1:0] washes;
    } t_stats;

    function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] c);
        return (c == CNT_MAX) ? c : c + CNT_W'(1);
    endfunction

    // Adds a positive delta to an unsigned count, clamping at the count limit.
    function automatic logic [CNT_W-1:0] cnt_add(input logic [CNT_W-1:0] c,
                                                 input logic [DELTA_W-1:0] d);
        logic [CNT_W:0] s;
        s = {1'b0, c} + (CNT_W+1)'(d);
        return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
    endfunction

    // Signed add of a delta to a sum, clamping at both ends of the range.
    function automatic logic [SUM_W-1:0] sum_add(input logic [SUM_W-1:0] a,
                                                 input logic [DELTA_W-1:0] d);
        logic signed [SUM_W:0] s;
        s = $signed({a[SUM_W-1], a}) + (SUM_W+1)'($signed(d));
        if (s[SUM_W] != s[SUM_W-1]) begin
            return s[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        return s[SUM_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/cpoa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module cpoa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== rtl/card_pair_outcome_accumulator_core.sv =====
// Top level of the card pair outcome accumulator: ranking, statistics RAM and update.
//
//  Channel   Handshake              Fields
//  -------   ---------------------  ---------------------------------------------
//  item in   start high, busy low   i_mode, i_first_card, i_second_card, i_delta
//  result    o_valid, one cycle     o_status, o_entry_index, o_record_count,
//                                   o_delta_total, o_win_total, o_loss_total,
//                                   o_win_count, o_loss_count, o_wash_count,
//                                   o_all_records
//
// An item passes through the rank, RAM read and update/write-back steps in that
// order, and the result strobes once the update is done; the next item can be
// accepted in the same cycle the result is shown.
// After reset the statistics RAM is cleared one entry a cycle, all PAIR_ENTRIES
// entries in turn, with busy held high; reset is synchronous and active low.
// The receiver cannot stall: each result is valid for exactly one cycle.
`default_nettype none
`include "card_pair_outcome_accumulator_core_assert.svh"
module card_pair_outcome_accumulator_core #(
    parameter int DECK_SIZE    = cpoa_pkg::DECK_SIZE_DEF,
    parameter int PAIR_ENTRIES = cpoa_pkg::PAIR_ENTRIES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_mode,
    input  wire logic [cpoa_pkg::CARD_W-1:0]   i_first_card,
    input  wire logic [cpoa_pkg::CARD_W-1:0]   i_second_card,
    input  wire logic [cpoa_pkg::DELTA_W-1:0]  i_delta,
    output logic                               o_valid,
    output logic                               o_status,
    output logic [cpoa_pkg::INDEX_W-1:0]       o_entry_index,
    output logic [cpoa_pkg::CNT_W-1:0]         o_record_count,
    output logic [cpoa_pkg::SUM_W-1:0]         o_delta_total,
    output logic [cpoa_pkg::CNT_W-1:0]         o_win_total,
    output logic [cpoa_pkg::SUM_W-1:0]         o_loss_total,
    output logic [cpoa_pkg::CNT_W-1:0]         o_win_count,
    output logic [cpoa_pkg::CNT_W-1:0]         o_loss_count,
    output logic [cpoa_pkg::CNT_W-1:0]         o_wash_count,
    output logic [cpoa_pkg::CNT_W-1:0]         o_all_records
);

    import cpoa_pkg::*;

    localparam int ADDR_W = (PAIR_ENTRIES > 1) ? $clog2(PAIR_ENTRIES) : 1;
    localparam int STAT_W = $bits(t_stats);
    localparam logic [RANK_W-1:0]   DECK_M1   = RANK_W'(DECK_SIZE - 1);
    localparam logic [RANK_W-1:0]   ENTRIES_R = RANK_W'(PAIR_ENTRIES);
    localparam logic [CARD_W:0]     DECK_C    = (CARD_W+1)'(DECK_SIZE);
    localparam logic [ADDR_W-1:0]   LAST_ADDR = ADDR_W'(PAIR_ENTRIES - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RANK,
        S_READ,
        S_MODIFY
    } t_state;

    t_state r_state;

    // Captured item.
    logic                 r_mode;
    logic [CARD_W-1:0]    r_card0;
    logic [CARD_W-1:0]    r_card1;
    logic [DELTA_W-1:0]   r_delta;

    // Ranked entry.
    logic                 r_bad;
    logic [ADDR_W-1:0]    r_addr;

    logic [ADDR_W-1:0]    r_clr_addr;
    logic [CNT_W-1:0]     r_total;

    // Result registers.
    logic                 r_valid;
    logic                 r_status;
    logic [INDEX_W-1:0]   r_index;
    t_stats               r_result;

    // Ranking of the captured pair.
    logic [CARD_W-1:0]    lo;
    logic [CARD_W-1:0]    hi;
    logic [CARD_W-1:0]    lo_m1;
    logic [RANK_W-1:0]    n_ix;
    logic                 n_bad;

    always_comb begin
        lo    = (r_card0 < r_card1) ? r_card0 : r_card1;
        hi    = (r_card0 < r_card1) ? r_card1 : r_card0;
        lo_m1 = (lo != '0) ? lo - CARD_W'(1) : lo;
        n_ix  = RANK_W'(lo) * DECK_M1
              - ((RANK_W'(lo) * RANK_W'(lo_m1)) >> 1)
              + RANK_W'(hi - lo - CARD_W'(1));
        n_bad = (r_card0 == r_card1) || ({1'b0, r_card0} >= DECK_C)
             || ({1'b0, r_card1} >= DECK_C) || (n_ix >= ENTRIES_R);
    end

    // RAM ports: the write side is shared by the clearing pass and write-back.
    t_stats               rd_stats;
    t_stats               n_stats;
    logic [STAT_W-1:0]    ram_rdata;
    logic [STAT_W-1:0]    ram_wdata;
    logic [ADDR_W-1:0]    ram_waddr;
    logic                 ram_we;
    logic                 ram_re;

    assign rd_stats = t_stats'(ram_rdata);

    // Read-modify step on the entry fetched in the previous cycle.
    logic                 d_pos;
    logic                 d_neg;

    always_comb begin
        d_neg   = r_delta[DELTA_W-1];
        d_pos   = !d_neg && (r_delta != '0);
        n_stats = rd_stats;
        if (!r_mode) begin
            n_stats.records   = cnt_inc(rd_stats.records);
            n_stats.delta_sum = sum_add(rd_stats.delta_sum, r_delta);
            if (d_pos) begin
                n_stats.win_sum = cnt_add(rd_stats.win_sum, r_delta);
                n_stats.wins    = cnt_inc(rd_stats.wins);
            end else if (d_neg) begin
                n_stats.loss_sum = sum_add(rd_stats.loss_sum, r_delta);
                n_stats.losses   = cnt_inc(rd_stats.losses);
            end else begin
                n_stats.washes = cnt_inc(rd_stats.washes);
            end
        end
    end

    always_comb begin
        ram_re    = (r_state == S_READ);
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = STAT_W'(n_stats);
        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '0;
            end
            S_MODIFY: begin
                ram_we = !r_mode;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    cpoa_ram #(
        .WIDTH (STAT_W),
        .DEPTH (PAIR_ENTRIES)
    ) u_stats_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    // Sequencer with its registered outputs. Only one item is in flight, so a
    // read never overlaps the write-back of an earlier item to the same entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_total    <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + ADDR_W'(1);
                    if (r_clr_addr == LAST_ADDR) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_mode  <= i_mode;
                        r_card0 <= i_first_card;
                        r_card1 <= i_second_card;
                        r_delta <= i_delta;
                        r_state <= S_RANK;
                    end
                end
                S_RANK: begin
                    r_bad   <= n_bad;
                    r_addr  <= n_bad ? '0 : n_ix[ADDR_W-1:0];
                    r_state <= S_READ;
                end
                S_READ: begin
                    r_state <= S_MODIFY;
                end
                S_MODIFY: begin
                    r_valid  <= 1'b1;
                    r_status <= r_bad;
                    r_index  <= INDEX_W'(r_addr);
                    r_result <= n_stats;
                    if (!r_mode) begin
                        r_total <= cnt_inc(r_total);
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_entry_index  = r_index;
    assign o_record_count = r_result.records;
    assign o_delta_total  = r_result.delta_sum;
    assign o_win_total    = r_result.win_sum;
    assign o_loss_total   = r_result.loss_sum;
    assign o_win_count    = r_result.wins;
    assign o_loss_count   = r_result.losses;
    assign o_wash_count   = r_result.washes;
    assign o_all_records  = r_total;

    // An accepted item always moves on to ranking.
    `CPOA_ASSERT_NXT(a_accept_ranks, i_clk, i_rst_n, start && !busy, r_state == S_RANK)
    // The update step always produces exactly one result strobe next cycle.
    `CPOA_ASSERT_NXT(a_modify_strobes, i_clk, i_rst_n, r_state == S_MODIFY, o_valid)
    // A result is only shown once the sequencer is free again.
    `CPOA_ASSERT_IMP(a_valid_not_busy, i_clk, i_rst_n, o_valid, !busy && !$past(o_valid))
    // An invalid pair is always redirected to entry zero.
    `CPOA_ASSERT_IMP(a_bad_entry_zero, i_clk, i_rst_n, o_valid && o_status, o_entry_index == '0)

endmodule
`default_nettype wire
